// ----- design/awss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// awss_pkg
// Shared types and fixed-point constants of the wheel speed split pipeline.
// ----------------------------------------------------------------------------
package awss_pkg;

	// Fixed-point constants
	localparam int              HALFPI_Q13 = 12868;            // pi/2 in Q2.13
	localparam longint unsigned HALFPI_Q30 = 64'd1686629713;   // pi/2 in Q30
	localparam longint unsigned Q30_ONE    = 64'd1073741824;
	localparam int              TAN_W      = 23;               // Q7.16 tangent
	localparam logic [TAN_W-1:0] TAN_SAT   = 23'h7FFFFF;
	localparam int              FRAC_W     = 14;               // interpolation fraction
	localparam int              ONE_Q16    = 65536;

	// Register reset values
	localparam logic [12:0] DEADBAND_RST = 13'd8;
	localparam logic [15:0] GEOMETRY_RST = 16'd16384;
	localparam logic [15:0] RLIMIT_RST   = 16'd19661;

	// Register indexes on the configuration channel
	typedef enum logic [1:0] {
		CFG_DEADBAND    = 2'd0,
		CFG_GEOMETRY    = 2'd1,
		CFG_RATIO_LIMIT = 2'd2
	} cfg_sel_t;

	// Configuration seen by the pipeline
	typedef struct packed {
		logic [12:0] angle_deadband;
		logic [15:0] geometry_factor;
		logic [15:0] ratio_limit;
	} cfg_t;

	// Per-item side data carried along the pipeline
	typedef struct packed {
		logic        sneg;      // body speed negative
		logic [15:0] smag;      // body speed magnitude
		logic        aneg;      // steering angle negative (left turn)
		logic        straight;  // angle magnitude inside the deadband
	} side_t;

endpackage
`default_nettype wire

// ----- design/awss_index.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// awss_index
// Stages 1 to 3: magnitudes, deadband test and table index/fraction of the angle.
// ----------------------------------------------------------------------------
module awss_index #(
	parameter int TAN_TABLE_SIZE = 256,
	localparam int IW = $clog2(TAN_TABLE_SIZE + 1)
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  signed [15:0]         body_speed,
	input  wire  signed [15:0]         steer_angle,
	input  awss_pkg::cfg_t             cfg,
	output logic                       out_valid,
	input  wire                        out_ready,
	output awss_pkg::side_t            out_side,
	output logic [IW-1:0]              out_idx,
	output logic [awss_pkg::FRAC_W-1:0] out_frac
);
	import awss_pkg::*;

	localparam int PW          = $clog2(HALFPI_Q13 * TAN_TABLE_SIZE + 1);
	localparam int RECIP_SHIFT = 32;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / HALFPI_Q13;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int MUL_W       = (PW + RECIP_W > RECIP_SHIFT + IW) ? PW + RECIP_W
	                                                              : RECIP_SHIFT + IW;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	side_t            side_s1, side_s2, side_s3;
	logic [PW-1:0]    p_s1, p_s2;
	logic [IW-1:0]    q0_s2, idx_s3;
	logic [FRAC_W-1:0] frac_s3;

	// stage 1 logic
	logic [15:0]       bs_u, an_u, amag;
	logic [FRAC_W-1:0] a_clamp;
	side_t             side_in;

	// stage 2 and 3 logic
	logic [MUL_W-1:0]  recip_prod;
	logic [PW-1:0]     qd, rem_full;
	logic [14:0]       rem;
	logic              rem_ge;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		bs_u             = $unsigned(body_speed);
		an_u             = $unsigned(steer_angle);
		side_in.sneg     = bs_u[15];
		side_in.smag     = bs_u[15] ? (~bs_u + 16'd1) : bs_u;
		side_in.aneg     = an_u[15];
		amag             = an_u[15] ? (~an_u + 16'd1) : an_u;
		side_in.straight = amag < {3'b000, cfg.angle_deadband};
		a_clamp          = (amag > 16'(HALFPI_Q13)) ? FRAC_W'(HALFPI_Q13) : amag[FRAC_W-1:0];
	end

	assign recip_prod = MUL_W'(p_s1) * MUL_W'(RECIP);

	always_comb begin
		qd       = PW'(q0_s2) * PW'(HALFPI_Q13);
		rem_full = p_s2 - qd;
		rem      = rem_full[14:0];
		rem_ge   = rem >= 15'(HALFPI_Q13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			side_s1 <= side_in;
			p_s1    <= PW'(a_clamp) * PW'(TAN_TABLE_SIZE);
		end
		if (rdy_s2 && vld_s1) begin
			side_s2 <= side_s1;
			p_s2    <= p_s1;
			q0_s2   <= recip_prod[RECIP_SHIFT +: IW];
		end
		if (rdy_s3 && vld_s2) begin
			side_s3 <= side_s2;
			idx_s3  <= rem_ge ? q0_s2 + IW'(1) : q0_s2;
			frac_s3 <= rem_ge ? FRAC_W'(rem - 15'(HALFPI_Q13)) : rem[FRAC_W-1:0];
		end
	end

	assign out_valid = vld_s3;
	assign out_side  = side_s3;
	assign out_idx   = idx_s3;
	assign out_frac  = frac_s3;

endmodule
`default_nettype wire

// ----- design/awss_tan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// awss_tan
// Stages 4 to 8: tangent ROM read and linear interpolation in Q7.16.
// ----------------------------------------------------------------------------
module awss_tan #(
	parameter int TAN_TABLE_SIZE = 256,
	localparam int IW = $clog2(TAN_TABLE_SIZE + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  awss_pkg::side_t             in_side,
	input  wire  [IW-1:0]               in_idx,
	input  wire  [awss_pkg::FRAC_W-1:0] in_frac,
	output logic                        out_valid,
	input  wire                         out_ready,
	output awss_pkg::side_t             out_side,
	output logic [awss_pkg::TAN_W-1:0]  out_tan
);
	import awss_pkg::*;

	localparam int ROM_BITS  = (TAN_TABLE_SIZE + 1) * TAN_W;
	localparam int PROD_W    = TAN_W + FRAC_W;     // diff * frac
	localparam int SPLIT     = 18;
	localparam int DIV_SHIFT = 37;
	localparam longint unsigned RECIP = (64'd1 << DIV_SHIFT) / HALFPI_Q13;
	localparam int RECIP_W   = $clog2(RECIP + 1);
	localparam int MH_W      = PROD_W - SPLIT + RECIP_W;
	localparam int ML_W      = SPLIT + RECIP_W;
	localparam int SUM_W     = MH_W + SPLIT + 1;
	localparam int Q_W       = TAN_W + 1;
	localparam int QD_W      = Q_W + FRAC_W;

	// shift-and-subtract quotient, used only while the table is built
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q, r;
		int          b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [TAN_W-1:0] tan_entry(input longint unsigned x);
		longint unsigned st, ct, q;
		longint          s, c;
		int              k;
		st = x;
		ct = Q30_ONE;
		s  = longint'(st);
		c  = longint'(ct);
		for (k = 1; k <= 11; k++) begin
			st = udiv((((st * x) >> 30) * x >> 30), 64'((2 * k) * (2 * k + 1)));
			ct = udiv((((ct * x) >> 30) * x >> 30), 64'((2 * k - 1) * (2 * k)));
			if (k[0]) begin
				s = s - longint'(st);
				c = c - longint'(ct);
			end else begin
				s = s + longint'(st);
				c = c + longint'(ct);
			end
		end
		if (c <= 0 || s < 0) return TAN_SAT;
		q = udiv($unsigned(s) * 64'd65536 + ($unsigned(c) >> 1), $unsigned(c));
		return (q > 64'(TAN_SAT)) ? TAN_SAT : TAN_W'(q);
	endfunction

	function automatic logic [ROM_BITS-1:0] build_rom();
		logic [ROM_BITS-1:0] r;
		longint unsigned     x;
		int                  i;
		r = '0;
		for (i = 0; i <= TAN_TABLE_SIZE; i++) begin
			x = udiv(64'(i) * HALFPI_Q30, 64'(TAN_TABLE_SIZE));
			r[i*TAN_W +: TAN_W] = tan_entry(x);
		end
		return r;
	endfunction

	localparam logic [ROM_BITS-1:0] TAN_ROM = build_rom();

	logic [TAN_W-1:0] rom [TAN_TABLE_SIZE+1];

	for (genvar g = 0; g <= TAN_TABLE_SIZE; g++) begin : g_rom
		assign rom[g] = TAN_ROM[g*TAN_W +: TAN_W];
	end

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	side_t             side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [TAN_W-1:0]  lo_s4, hi_s4, lo_s5, lo_s6, lo_s7, tan_s8;
	logic [FRAC_W-1:0] frac_s4;
	logic [PROD_W-1:0] prod_s5, prod_s6, prod_s7;
	logic [MH_W-1:0]   mh_s6;
	logic [ML_W-1:0]   ml_s6;
	logic [Q_W-1:0]    q0_s7;

	logic [IW-1:0]     hi_addr;
	logic [TAN_W-1:0]  diff;
	logic [SUM_W-1:0]  sum;
	logic [QD_W-1:0]   qd, rem;
	logic [Q_W-1:0]    q, t_sum;

	assign rdy_s8   = !vld_s8 || out_ready;
	assign rdy_s7   = !vld_s7 || rdy_s8;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	// the last entry pairs with itself; its fraction is always zero
	assign hi_addr = (in_idx == IW'(TAN_TABLE_SIZE)) ? in_idx : in_idx + IW'(1);

	always_comb begin
		diff  = (hi_s4 >= lo_s4) ? hi_s4 - lo_s4 : '0;
		sum   = SUM_W'({mh_s6, {SPLIT{1'b0}}}) + SUM_W'(ml_s6);
		qd    = QD_W'(q0_s7) * QD_W'(HALFPI_Q13);
		rem   = QD_W'(prod_s7) - qd;
		q     = (rem >= QD_W'(HALFPI_Q13)) ? q0_s7 + Q_W'(1) : q0_s7;
		t_sum = Q_W'(lo_s7) + q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= in_valid;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			side_s4 <= in_side;
			frac_s4 <= in_frac;
			lo_s4   <= rom[in_idx];
			hi_s4   <= rom[hi_addr];
		end
		if (rdy_s5 && vld_s4) begin
			side_s5 <= side_s4;
			lo_s5   <= lo_s4;
			prod_s5 <= PROD_W'(diff) * PROD_W'(frac_s4);
		end
		// divide by pi/2 in Q2.13 through the reciprocal, in two partial products
		if (rdy_s6 && vld_s5) begin
			side_s6 <= side_s5;
			lo_s6   <= lo_s5;
			prod_s6 <= prod_s5;
			mh_s6   <= MH_W'(prod_s5[PROD_W-1:SPLIT]) * MH_W'(RECIP);
			ml_s6   <= ML_W'(prod_s5[SPLIT-1:0]) * ML_W'(RECIP);
		end
		if (rdy_s7 && vld_s6) begin
			side_s7 <= side_s6;
			lo_s7   <= lo_s6;
			prod_s7 <= prod_s6;
			q0_s7   <= sum[DIV_SHIFT +: Q_W];
		end
		if (rdy_s8 && vld_s7) begin
			side_s8 <= side_s7;
			tan_s8  <= (t_sum > Q_W'(TAN_SAT)) ? TAN_SAT : t_sum[TAN_W-1:0];
		end
	end

	assign out_valid = vld_s8;
	assign out_side  = side_s8;
	assign out_tan   = tan_s8;

endmodule
`default_nettype wire

// ----- design/awss_wheel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// awss_wheel
// Stages 9 to 12: split ratio, wheel factors and rounded wheel speeds.
// ----------------------------------------------------------------------------
module awss_wheel (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  awss_pkg::side_t            in_side,
	input  wire  [awss_pkg::TAN_W-1:0] in_tan,
	input  awss_pkg::cfg_t             cfg,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic signed [16:0]         left_speed,
	output logic signed [16:0]         right_speed
);
	import awss_pkg::*;

	localparam int GT_W = 16 + TAN_W + 1;

	logic vld_s9, vld_s10, vld_s11, vld_s12;
	logic rdy_s9, rdy_s10, rdy_s11, rdy_s12;

	side_t            side_s9, side_s10, side_s11;
	logic [TAN_W-1:0] mraw_s9;
	logic [16:0]      fl_s10, fr_s10;
	logic [32:0]      pl_s11, pr_s11;
	logic [16:0]      left_s12, right_s12;

	logic [GT_W-1:0]  gt;
	logic [15:0]      m;
	logic [16:0]      f_plus, f_minus;
	logic [33:0]      rl_sum, rr_sum;
	logic [16:0]      vl, vr;

	assign rdy_s12  = !vld_s12 || out_ready;
	assign rdy_s11  = !vld_s11 || rdy_s12;
	assign rdy_s10  = !vld_s10 || rdy_s11;
	assign rdy_s9   = !vld_s9 || rdy_s10;
	assign in_ready = rdy_s9;

	always_comb begin
		gt = GT_W'(cfg.geometry_factor) * GT_W'(in_tan) + GT_W'(32768);
		// straight driving forces a zero ratio: both factors become one
		if (side_s9.straight)
			m = '0;
		else if (mraw_s9 > TAN_W'(cfg.ratio_limit))
			m = cfg.ratio_limit;
		else
			m = mraw_s9[15:0];
		f_plus  = 17'(ONE_Q16) + {1'b0, m};
		f_minus = 17'(ONE_Q16) - {1'b0, m};
		rl_sum  = 34'(pl_s11) + 34'(32768);
		rr_sum  = 34'(pr_s11) + 34'(32768);
		vl      = rl_sum[32:16];
		vr      = rr_sum[32:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			if (rdy_s9)  vld_s9  <= in_valid;
			if (rdy_s10) vld_s10 <= vld_s9;
			if (rdy_s11) vld_s11 <= vld_s10;
			if (rdy_s12) vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s9 && in_valid) begin
			side_s9 <= in_side;
			mraw_s9 <= gt[16 +: TAN_W];
		end
		if (rdy_s10 && vld_s9) begin
			side_s10 <= side_s9;
			fl_s10   <= side_s9.aneg ? f_minus : f_plus;
			fr_s10   <= side_s9.aneg ? f_plus : f_minus;
		end
		if (rdy_s11 && vld_s10) begin
			side_s11 <= side_s10;
			pl_s11   <= 33'(side_s10.smag) * 33'(fl_s10);
			pr_s11   <= 33'(side_s10.smag) * 33'(fr_s10);
		end
		if (rdy_s12 && vld_s11) begin
			left_s12  <= side_s11.sneg ? 17'd0 - vl : vl;
			right_s12 <= side_s11.sneg ? 17'd0 - vr : vr;
		end
	end

	assign out_valid   = vld_s12;
	assign left_speed  = $signed(left_s12);
	assign right_speed = $signed(right_s12);

endmodule
`default_nettype wire

// ----- design/ackermann_wheel_speed_split.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ackermann_wheel_speed_split
// Splits a body speed into left and right wheel speeds by the steering angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_*: body speed (mm/s) and steering angle
//   (Q2.13 rad, negative turns left). One result item per input item leaves
//   on m_axis_*: left and right wheel target speeds in mm/s.
//   Registers are written on the cfg_* channel (0: angle deadband,
//   1: geometry factor, 2: ratio limit); cfg_ready is always high and an
//   index past the list is dropped. Write only while the block is idle.
// Throughput: one item per clock while m_axis_tready is held high, set by
//   the twelve-stage pipeline.
// Stall: each stage holds its item while the next one is full, so bubbles
//   close up and s_axis_tready stays high while any stage is free.
// Reset: arst_n clears every valid bit and loads the register defaults;
//   the tangent table is a constant ROM and needs no fill.
// ----------------------------------------------------------------------------
module ackermann_wheel_speed_split #(
	parameter int TAN_TABLE_SIZE = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [15:0] body_speed, [31:16] steer_angle
	// result items
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [16:0] left_speed, [33:17] right_speed, zero pad
	// register writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import awss_pkg::*;

	localparam int IW = $clog2(TAN_TABLE_SIZE + 1);

	cfg_t cfg_q;

	// index stage group to tangent stage group
	logic              ix_valid, ix_ready;
	side_t             ix_side;
	logic [IW-1:0]     ix_idx;
	logic [FRAC_W-1:0] ix_frac;

	// tangent stage group to wheel stage group
	logic              tn_valid, tn_ready;
	side_t             tn_side;
	logic [TAN_W-1:0]  tn_tan;

	logic signed [16:0] left_speed, right_speed;

	assign cfg_ready = 1'b1;

	// Hold the registers; take a write whenever one is offered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_deadband  <= DEADBAND_RST;
			cfg_q.geometry_factor <= GEOMETRY_RST;
			cfg_q.ratio_limit     <= RLIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_sel_t'(cfg_index))
				CFG_DEADBAND:    cfg_q.angle_deadband  <= cfg_data[12:0];
				CFG_GEOMETRY:    cfg_q.geometry_factor <= cfg_data;
				CFG_RATIO_LIMIT: cfg_q.ratio_limit     <= cfg_data;
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	// Stages 1-3: magnitudes, deadband, table index and fraction.
	awss_index #(
		.TAN_TABLE_SIZE (TAN_TABLE_SIZE)
	) u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.body_speed  ($signed(s_axis_tdata[15:0])),
		.steer_angle ($signed(s_axis_tdata[31:16])),
		.cfg         (cfg_q),
		.out_valid   (ix_valid),
		.out_ready   (ix_ready),
		.out_side    (ix_side),
		.out_idx     (ix_idx),
		.out_frac    (ix_frac)
	);

	// Stages 4-8: ROM read and interpolation of the tangent.
	awss_tan #(
		.TAN_TABLE_SIZE (TAN_TABLE_SIZE)
	) u_tan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ix_valid),
		.in_ready  (ix_ready),
		.in_side   (ix_side),
		.in_idx    (ix_idx),
		.in_frac   (ix_frac),
		.out_valid (tn_valid),
		.out_ready (tn_ready),
		.out_side  (tn_side),
		.out_tan   (tn_tan)
	);

	// Stages 9-12: ratio, clamp, wheel factors and rounded speeds.
	awss_wheel u_wheel (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (tn_valid),
		.in_ready    (tn_ready),
		.in_side     (tn_side),
		.in_tan      (tn_tan),
		.cfg         (cfg_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.left_speed  (left_speed),
		.right_speed (right_speed)
	);

	assign m_axis_tdata = {6'b000000, $unsigned(right_speed), $unsigned(left_speed)};

endmodule
`default_nettype wire

// ----- design/awss_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// awss_checker
// Port-level checks of the wheel speed split, bound to the top level.
// ----------------------------------------------------------------------------
module awss_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [39:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// a free output slot lets the whole pipeline move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while the output slot was free");

	// both wheels turn the same way as the body, unless one rounds to zero
	a_same_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[16] == m_axis_tdata[33]) ||
		                  (m_axis_tdata[16:0] == 17'd0) || (m_axis_tdata[33:17] == 17'd0))
		else $error("left and right wheel speeds of opposite sign");

	// no result in the cycle after a reset edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result item shown after reset");

endmodule

bind ackermann_wheel_speed_split awss_checker u_awss_checker (.*);
`default_nettype wire
